// ===== src/tite_pkg.sv =====
// shared types and constants for the tape image text extractor
package tite_pkg;

	localparam int HEADER_SKIP_DEF  = 9;
	localparam int BLOCK_BYTES_DEF  = 256;
	localparam int PREFIX_BYTES_DEF = 2;

	localparam logic [7:0] SYNC_BYTE  = 8'h24;
	localparam logic [7:0] CR_BYTE    = 8'h0d;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;

	typedef enum logic [2:0] {
		PH_SYNC   = 3'd0,
		PH_HEADER = 3'd1,
		PH_NAME   = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// framer to line filter
	typedef struct packed {
		logic text_en;     // current byte is a text byte
		logic line_reset;  // start of data, clear line state
	} frame_ctl_t;

	// line filter result for the current byte
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       eot;
	} text_res_t;

endpackage

// ===== src/tite_framer.sv =====
// tape framing: sync hunt, header and name skip, block prefix removal
module tite_framer #(
	parameter int HEADER_SKIP  = tite_pkg::HEADER_SKIP_DEF,
	parameter int BLOCK_BYTES  = tite_pkg::BLOCK_BYTES_DEF,
	parameter int PREFIX_BYTES = tite_pkg::PREFIX_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	input  logic                 text_done,
	output tite_pkg::frame_ctl_t ctl
);
	import tite_pkg::*;

	localparam int BLK_W = $clog2(BLOCK_BYTES);

	phase_t             phase_q, phase_d;
	logic [3:0]         header_count_q, header_count_d;
	logic [BLK_W-1:0]   block_pos_q, block_pos_d;
	logic [1:0]         prefix_count_q, prefix_count_d;
	logic [BLK_W:0]     block_next;
	logic               in_prefix;

	assign block_next = (BLK_W+1)'(block_pos_q) + (BLK_W+1)'(1);
	assign in_prefix  = (block_pos_q == '0) && (prefix_count_q < 2'(PREFIX_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SYNC;
			header_count_q <= '0;
			block_pos_q    <= '0;
			prefix_count_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			block_pos_q    <= block_pos_d;
			prefix_count_q <= prefix_count_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		header_count_d = header_count_q;
		block_pos_d    = block_pos_q;
		prefix_count_d = prefix_count_q;
		ctl.text_en    = 1'b0;
		ctl.line_reset = 1'b0;
		unique case (phase_q)
			PH_SYNC: begin
				if (byte_in == SYNC_BYTE) begin
					header_count_d = '0;
					phase_d = (HEADER_SKIP == 0) ? PH_NAME : PH_HEADER;
				end
			end
			PH_HEADER: begin
				header_count_d = header_count_q + 4'd1;
				if ((5'(header_count_q) + 5'd1) >= 5'(HEADER_SKIP))
					phase_d = PH_NAME;
			end
			PH_NAME: begin
				if (byte_in == ZERO_BYTE) begin
					phase_d        = PH_DATA;
					block_pos_d    = '0;
					prefix_count_d = '0;
					ctl.line_reset = 1'b1;
				end
			end
			PH_DATA: begin
				if (in_prefix) begin
					prefix_count_d = prefix_count_q + 2'd1;
				end else begin
					prefix_count_d = '0;
					ctl.text_en    = 1'b1;
					if (block_next >= (BLK_W+1)'(BLOCK_BYTES))
						block_pos_d = '0;
					else
						block_pos_d = block_next[BLK_W-1:0];
					if (text_done)
						phase_d = PH_DONE;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/tite_line_filter.sv =====
// per-line text filter: number stripping, zero suppression, end detection
module tite_line_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	input  logic                 strip,
	input  tite_pkg::frame_ctl_t ctl,
	output tite_pkg::text_res_t  res,
	output logic                 text_done
);
	import tite_pkg::*;

	logic dropping_q, dropping_d;
	logic kept_empty_q, kept_empty_d;
	logic suppress_q, suppress_d;
	logic looking;
	logic emit;

	assign looking = strip && !dropping_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropping_q   <= 1'b0;
			kept_empty_q <= 1'b1;
			suppress_q   <= 1'b0;
		end else if (step && ctl.line_reset) begin
			dropping_q   <= 1'b0;
			kept_empty_q <= 1'b1;
			suppress_q   <= 1'b0;
		end else if (step && ctl.text_en) begin
			dropping_q   <= dropping_d;
			kept_empty_q <= kept_empty_d;
			suppress_q   <= suppress_d;
		end
	end

	always_comb begin
		dropping_d   = dropping_q;
		kept_empty_d = kept_empty_q;
		suppress_d   = suppress_q;
		emit         = 1'b0;
		res.data     = byte_in;
		res.eot      = 1'b0;
		text_done    = 1'b0;
		if (byte_in == CR_BYTE) begin
			if (kept_empty_q) begin
				emit      = 1'b1;
				res.eot   = 1'b1;
				text_done = ctl.text_en;
			end else if (looking || !suppress_q) begin
				emit = 1'b1;
			end
			dropping_d   = 1'b0;
			kept_empty_d = 1'b1;
			suppress_d   = 1'b0;
		end else if (looking) begin
			if (byte_in == SPACE_BYTE) begin
				dropping_d   = 1'b1;
				kept_empty_d = 1'b1;
			end else begin
				kept_empty_d = 1'b0;
			end
		end else begin
			kept_empty_d = 1'b0;
			if (!suppress_q) begin
				if (byte_in == ZERO_BYTE)
					suppress_d = 1'b1;
				else
					emit = 1'b1;
			end
		end
		res.valid = ctl.text_en && emit;
	end

endmodule

// ===== src/tape_image_text_extractor_unit.sv =====
// top level of the tape image text extractor
//
//  channel  | direction | signals                        | contents
//  ---------+-----------+--------------------------------+---------------------------------
//  s_axis   | in        | tvalid tready tdata[7:0]       | in_byte, one raw tape byte
//  m_axis   | out       | tvalid tready tdata[7:0] tlast | out_byte, tlast = end_of_text
//  cfg      | in        | cfg_wr_en cfg_wr_data[0]       | strip_line_numbers
//
// one byte per cycle sustained while no waiting result stalls; an accepted byte is held in
// the input register, then framing and line logic load its result into the output register
// reset puts the framer in sync hunt, clears the line state and stripping
// a waiting result stalls only a byte that itself makes a result; dropped bytes flow on
// after the end-of-text CR every further byte is taken and discarded
module tape_image_text_extractor_unit #(
	parameter int HEADER_SKIP  = tite_pkg::HEADER_SKIP_DEF,
	parameter int BLOCK_BYTES  = tite_pkg::BLOCK_BYTES_DEF,
	parameter int PREFIX_BYTES = tite_pkg::PREFIX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // end_of_text
	input  logic       cfg_wr_en,
	input  logic [0:0] cfg_wr_data     // [0] strip_line_numbers
);
	import tite_pkg::*;

	// config register
	logic strip_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_eot_q;

	frame_ctl_t ctl;
	text_res_t  res;
	logic       text_done;
	logic       advance;
	logic       step;

	// the staged byte moves on when it makes no result or the result slot frees up
	assign advance       = !out_valid_q || m_axis_tready || !res.valid;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strip_q <= 1'b0;
		else if (cfg_wr_en)
			strip_q <= cfg_wr_data[0];
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			data_s1 <= s_axis_tdata;
	end

	tite_framer #(
		.HEADER_SKIP  (HEADER_SKIP),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.PREFIX_BYTES (PREFIX_BYTES)
	) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (data_s1),
		.text_done (text_done),
		.ctl       (ctl)
	);

	tite_line_filter u_line_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (data_s1),
		.strip     (strip_q),
		.ctl       (ctl),
		.res       (res),
		.text_done (text_done)
	);

	// result register: load on a producing step, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && res.valid)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_byte_q <= res.data;
			out_eot_q  <= res.eot;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_eot_q;

endmodule
